// File: rtl/voxel_grid_ray_march_assert.svh
// Assertion macros for the voxel ray march block.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef VOXEL_GRID_RAY_MARCH_ASSERT_SVH
`define VOXEL_GRID_RAY_MARCH_ASSERT_SVH

// Antecedent holds, consequent holds in the same cycle.
`define VGRM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Antecedent holds, consequent holds in the following cycle.
`define VGRM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vgrm_pkg.sv
// Shared constants, types and helpers of the voxel ray march block.
// No dependencies.
package vgrm_pkg;

  localparam int GRID_SIZE = 32;
  localparam int FRAC_BITS = 16;
  localparam int MAX_STEPS = 96;

  localparam int CW     = $clog2(GRID_SIZE);
  localparam int ADDR_W = 3 * CW;
  localparam int CELLS  = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  localparam int ORIG_W = 21;
  localparam int DISP_W = 22;
  localparam int MAG_W  = DISP_W;
  localparam int SQ_W   = 2 * MAG_W + 2;
  localparam int LEN_W  = SQ_W / 2;
  localparam int REM_W  = LEN_W + 3;
  localparam int GAP_W  = FRAC_BITS + 1;
  localparam int DVD_W  = GAP_W + LEN_W;
  localparam int T_W    = DVD_W + 1;
  localparam int CUR_W  = 9;
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int DIST_W = 21;
  localparam int OUT_C_W = 8;
  localparam int PROD_W = 2 * MAG_W;

  localparam longint SQRT3_Q30 = 64'd1859775393;
  localparam longint SQRT3_QL  =
    (SQRT3_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
  localparam logic [T_W-1:0]    SQRT3_Q  = T_W'(SQRT3_QL);
  localparam logic [T_W-1:0]    T_NEVER  = '1;
  localparam logic [LEN_W-1:0]  DIST_MAX = LEN_W'((64'd1 << DIST_W) - 1);

  localparam logic [1:0] ST_MISS = 2'd0;
  localparam logic [1:0] ST_HIT  = 2'd1;
  localparam logic [1:0] ST_TIE  = 2'd2;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_MARCH = 1'b1;

  typedef enum logic [11:0] {
    S_CLR   = 12'b0000_0000_0001,
    S_IDLE  = 12'b0000_0000_0010,
    S_SQ    = 12'b0000_0000_0100,
    S_ROOT  = 12'b0000_0000_1000,
    S_AXIS  = 12'b0000_0001_0000,
    S_MUL   = 12'b0000_0010_0000,
    S_DIV   = 12'b0000_0100_0000,
    S_SEL   = 12'b0000_1000_0000,
    S_STEP  = 12'b0001_0000_0000,
    S_READ  = 12'b0010_0000_0000,
    S_CHECK = 12'b0100_0000_0000,
    S_OUT   = 12'b1000_0000_0000
  } state_e;

  function automatic logic signed [OUT_C_W-1:0] sat8(input logic signed [CUR_W-1:0] v);
    logic signed [OUT_C_W-1:0] r;
    if (v > CUR_W'(signed'(127)))       r = 8'sd127;
    else if (v < -CUR_W'(signed'(128))) r = -8'sd128;
    else                                r = v[OUT_C_W-1:0];
    return r;
  endfunction

endpackage

// File: rtl/vgrm_if.sv
// Channel interfaces of the voxel ray march block: march/write words in, results out.
// Depends on vgrm_pkg.
interface vgrm_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [vgrm_pkg::CW-1:0]        cell_x;
  logic [vgrm_pkg::CW-1:0]        cell_y;
  logic [vgrm_pkg::CW-1:0]        cell_z;
  logic                           solid;
  logic [vgrm_pkg::ORIG_W-1:0]    origin_x;
  logic [vgrm_pkg::ORIG_W-1:0]    origin_y;
  logic [vgrm_pkg::ORIG_W-1:0]    origin_z;
  logic signed [vgrm_pkg::DISP_W-1:0] disp_x;
  logic signed [vgrm_pkg::DISP_W-1:0] disp_y;
  logic signed [vgrm_pkg::DISP_W-1:0] disp_z;

  modport source (output valid, func, cell_x, cell_y, cell_z, solid, origin_x, origin_y,
                  origin_z, disp_x, disp_y, disp_z, input ready);
  modport sink   (input valid, func, cell_x, cell_y, cell_z, solid, origin_x, origin_y,
                  origin_z, disp_x, disp_y, disp_z, output ready);
endinterface

interface vgrm_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [vgrm_pkg::DIST_W-1:0]        distance;
  logic signed [vgrm_pkg::OUT_C_W-1:0] hit_x;
  logic signed [vgrm_pkg::OUT_C_W-1:0] hit_y;
  logic signed [vgrm_pkg::OUT_C_W-1:0] hit_z;
  logic signed [vgrm_pkg::OUT_C_W-1:0] prev_x;
  logic signed [vgrm_pkg::OUT_C_W-1:0] prev_y;
  logic signed [vgrm_pkg::OUT_C_W-1:0] prev_z;

  modport source (output valid, status, distance, hit_x, hit_y, hit_z, prev_x, prev_y,
                  prev_z, input ready);
  modport sink   (input valid, status, distance, hit_x, hit_y, hit_z, prev_x, prev_y,
                  prev_z, output ready);
endinterface

// File: rtl/voxel_grid_ray_march.sv
// Voxel ray march: occupancy store plus a sequenced fixed-point grid walker.
// Depends on vgrm_pkg, vgrm_if.sv and voxel_grid_ray_march_assert.svh.
//
//  channel | dir | handshake      | word
//  in_i    | in  | valid / ready  | func, cell_x/y/z, solid, origin_x/y/z, disp_x/y/z
//  out_o   | out | valid / ready  | status, distance, hit_x/y/z, prev_x/y/z
//
// A write word is stored as it is accepted. A march word first squares and sums the three
// magnitudes and takes the root for the length, then per moving axis runs a multiply and
// two divisions (a still axis skips them), then reads each cell entered (at most MAX_STEPS
// cells) and closes; the single restoring divider gives one quotient bit per cycle.
// After reset a clearing pass over all GRID_SIZE^3 cells (32768) zeroes the store;
// in_i.ready stays low until it ends. in_i.ready is high only while idle; a finished
// result moves into the output register and waits there until taken, so the next word
// enters meanwhile; a march that finishes while the register is still full holds in S_OUT.
module voxel_grid_ray_march (
  input  logic          clk_i,
  input  logic          rst_ni,
  vgrm_in_if.sink       in_i,
  vgrm_out_if.source    out_o
);
  import vgrm_pkg::*;

  // Control state
  state_e              state_q;
  logic [ADDR_W-1:0]   clr_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [1:0]          ax_q;
  logic                ph_q;
  logic [1:0]          a_q;
  logic [STEP_W-1:0]   steps_q;
  logic                res_valid_q;

  // Datapath registers
  logic [MAG_W-1:0]    mag_q  [3];
  logic                neg_q  [3];
  logic [GAP_W-1:0]    gap_q  [3];
  logic [T_W-1:0]      tmax_q [3];
  logic [T_W-1:0]      tdel_q [3];
  logic signed [CUR_W-1:0] cur_q  [3];
  logic signed [CUR_W-1:0] prev_q [3];
  logic [SQ_W-1:0]     sq_q;
  logic [SQ_W-1:0]     prod_q;
  logic [REM_W-1:0]    srem_q;
  logic [LEN_W-1:0]    len_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [MAG_W-1:0]    drem_q;
  logic [LEN_W-1:0]    t_q;
  logic [1:0]          status_q;

  // Output register
  logic [1:0]               res_status_q;
  logic [DIST_W-1:0]        res_dist_q;
  logic signed [OUT_C_W-1:0] res_hit_q  [3];
  logic signed [OUT_C_W-1:0] res_prev_q [3];

  // Occupancy store
  logic                occ_mem [CELLS];
  logic                rd_q;
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic                mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic accept;
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // Move a finished result into the output register once it is free or being taken
  logic load_out;
  assign load_out = (state_q == S_OUT) && (!res_valid_q || out_o.ready);

  // Store port: clearing pass or a write word
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = 1'b0;
    if (state_q == S_CLR) begin
      mem_we = 1'b1;
    end else if (accept && in_i.func == FUNC_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = {in_i.cell_z, in_i.cell_y, in_i.cell_x};
      mem_wdata = in_i.solid;
    end
  end

  assign mem_raddr = {cur_q[2][CW-1:0], cur_q[1][CW-1:0], cur_q[0][CW-1:0]};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= occ_mem[mem_raddr];
  end

  // Current cell inside the store: every coordinate non-negative and below GRID_SIZE
  logic in_grid;
  always_comb begin
    in_grid = 1'b1;
    for (int i = 0; i < 3; i++) begin
      if (cur_q[i][CUR_W-1:CW] != '0) in_grid = 1'b0;
    end
  end

  // Integer square root, two radicand bits a cycle
  logic [REM_W-1:0] srem_sh, strial;
  logic             sroot_ge;
  assign srem_sh  = {srem_q[REM_W-3:0], sq_q[SQ_W-1 -: 2]};
  assign strial   = REM_W'({len_q, 2'b01});
  assign sroot_ge = (srem_sh >= strial);

  // Restoring divider, one quotient bit a cycle
  logic [MAG_W:0] drem_sh;
  logic           dq_bit;
  assign drem_sh = {drem_q, dvd_q[DVD_W-1]};
  assign dq_bit  = (drem_sh >= {1'b0, mag_q[ax_q]});

  // Axis pick and step arithmetic
  logic [1:0]     a_pick;
  logic [T_W-1:0] step_len;
  logic           loop_done;
  always_comb begin
    a_pick = 2'd0;
    if (tmax_q[1] < tmax_q[0])      a_pick = 2'd1;
    if (tmax_q[2] < tmax_q[a_pick]) a_pick = 2'd2;
  end
  assign step_len  = tmax_q[a_q] - T_W'(t_q);
  assign loop_done = (len_q == '0) || (t_q >= len_q) || (steps_q >= STEP_W'(MAX_STEPS));

  logic last_axis;
  assign last_axis = (ax_q == 2'd2);

  // Control: sequencer with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      cnt_q       <= '0;
      ax_q        <= '0;
      ph_q        <= 1'b0;
      a_q         <= '0;
      steps_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(CELLS - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && in_i.func == FUNC_MARCH) begin
            cnt_q   <= '0;
            state_q <= S_SQ;
          end
        end
        S_SQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(3)) begin
            cnt_q   <= '0;
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(LEN_W - 1)) begin
            ax_q    <= '0;
            ph_q    <= 1'b0;
            state_q <= S_AXIS;
          end
        end
        S_AXIS: begin
          cnt_q <= '0;
          if (mag_q[ax_q] == '0) begin
            ax_q <= ax_q + 1'b1;
            if (last_axis) begin
              steps_q <= '0;
              state_q <= S_SEL;
            end
          end else if (!ph_q) begin
            state_q <= S_MUL;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_MUL: state_q <= S_DIV;
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(DVD_W - 1)) begin
            ph_q <= !ph_q;
            if (ph_q) begin
              ax_q <= ax_q + 1'b1;
              if (last_axis) begin
                steps_q <= '0;
                state_q <= S_SEL;
              end else begin
                state_q <= S_AXIS;
              end
            end else begin
              state_q <= S_AXIS;
            end
          end
        end
        S_SEL: begin
          a_q <= a_pick;
          state_q <= loop_done ? S_OUT : S_STEP;
        end
        S_STEP: begin
          if ((step_len >= SQRT3_Q && T_W'(len_q) >= SQRT3_Q) ||
              (tmax_q[a_q] > T_W'(len_q))) begin
            state_q <= S_OUT;
          end else begin
            steps_q <= steps_q + 1'b1;
            state_q <= S_READ;
          end
        end
        S_READ:  state_q <= S_CHECK;
        S_CHECK: state_q <= (in_grid && rd_q) ? S_OUT : S_SEL;
        S_OUT:   if (load_out) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Datapath: no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (accept && in_i.func == FUNC_MARCH) begin
          mag_q[0] <= in_i.disp_x[DISP_W-1] ? MAG_W'(-in_i.disp_x) : MAG_W'(in_i.disp_x);
          mag_q[1] <= in_i.disp_y[DISP_W-1] ? MAG_W'(-in_i.disp_y) : MAG_W'(in_i.disp_y);
          mag_q[2] <= in_i.disp_z[DISP_W-1] ? MAG_W'(-in_i.disp_z) : MAG_W'(in_i.disp_z);
          neg_q[0] <= in_i.disp_x[DISP_W-1];
          neg_q[1] <= in_i.disp_y[DISP_W-1];
          neg_q[2] <= in_i.disp_z[DISP_W-1];
          // gap to the first boundary in the direction of travel
          gap_q[0] <= in_i.disp_x[DISP_W-1] ? GAP_W'(in_i.origin_x[FRAC_BITS-1:0])
                    : (GAP_W'(1) << FRAC_BITS) - GAP_W'(in_i.origin_x[FRAC_BITS-1:0]);
          gap_q[1] <= in_i.disp_y[DISP_W-1] ? GAP_W'(in_i.origin_y[FRAC_BITS-1:0])
                    : (GAP_W'(1) << FRAC_BITS) - GAP_W'(in_i.origin_y[FRAC_BITS-1:0]);
          gap_q[2] <= in_i.disp_z[DISP_W-1] ? GAP_W'(in_i.origin_z[FRAC_BITS-1:0])
                    : (GAP_W'(1) << FRAC_BITS) - GAP_W'(in_i.origin_z[FRAC_BITS-1:0]);
          cur_q[0]  <= CUR_W'(in_i.origin_x[ORIG_W-1:FRAC_BITS]);
          cur_q[1]  <= CUR_W'(in_i.origin_y[ORIG_W-1:FRAC_BITS]);
          cur_q[2]  <= CUR_W'(in_i.origin_z[ORIG_W-1:FRAC_BITS]);
          prev_q[0] <= CUR_W'(in_i.origin_x[ORIG_W-1:FRAC_BITS]);
          prev_q[1] <= CUR_W'(in_i.origin_y[ORIG_W-1:FRAC_BITS]);
          prev_q[2] <= CUR_W'(in_i.origin_z[ORIG_W-1:FRAC_BITS]);
          sq_q      <= '0;
          t_q       <= '0;
          status_q  <= ST_MISS;
        end
      end
      S_SQ: begin
        // square one magnitude a cycle, accumulate the previous square
        if (cnt_q != CNT_W'(3)) begin
          prod_q <= SQ_W'(PROD_W'(mag_q[cnt_q[1:0]]) * PROD_W'(mag_q[cnt_q[1:0]]));
        end
        if (cnt_q != '0) sq_q <= sq_q + prod_q;
        srem_q <= '0;
        len_q  <= '0;
      end
      S_ROOT: begin
        sq_q   <= sq_q << 2;
        srem_q <= sroot_ge ? (srem_sh - strial) : srem_sh;
        len_q  <= {len_q[LEN_W-2:0], sroot_ge};
      end
      S_AXIS: begin
        drem_q <= '0;
        if (mag_q[ax_q] == '0) begin
          tmax_q[ax_q] <= T_NEVER;
          tdel_q[ax_q] <= '0;
        end else if (ph_q) begin
          dvd_q <= DVD_W'(len_q) << FRAC_BITS;
        end
      end
      S_MUL: dvd_q <= DVD_W'(gap_q[ax_q]) * DVD_W'(len_q);
      S_DIV: begin
        drem_q <= dq_bit ? MAG_W'(drem_sh - {1'b0, mag_q[ax_q]}) : drem_sh[MAG_W-1:0];
        dvd_q  <= {dvd_q[DVD_W-2:0], dq_bit};
        if (cnt_q == CNT_W'(DVD_W - 1)) begin
          if (ph_q) tdel_q[ax_q] <= T_W'({dvd_q[DVD_W-2:0], dq_bit});
          else      tmax_q[ax_q] <= T_W'({dvd_q[DVD_W-2:0], dq_bit});
        end
      end
      S_STEP: begin
        if (step_len >= SQRT3_Q && T_W'(len_q) >= SQRT3_Q) begin
          status_q <= ST_TIE;
        end else if (tmax_q[a_q] > T_W'(len_q)) begin
          t_q <= len_q;
        end else begin
          // enter the neighbour along the chosen axis
          t_q          <= tmax_q[a_q][LEN_W-1:0];
          prev_q       <= cur_q;
          cur_q[a_q]   <= neg_q[a_q] ? cur_q[a_q] - 1'b1 : cur_q[a_q] + 1'b1;
          tmax_q[a_q]  <= tmax_q[a_q] + tdel_q[a_q];
        end
      end
      S_CHECK: if (in_grid && rd_q) status_q <= ST_HIT;
      default: ;
    endcase
  end

  // Output register: capture the finished march, hold it until taken
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      res_status_q <= status_q;
      res_dist_q   <= (t_q > DIST_MAX) ? DIST_W'(DIST_MAX) : t_q[DIST_W-1:0];
      for (int i = 0; i < 3; i++) begin
        res_hit_q[i]  <= (status_q == ST_HIT) ? sat8(cur_q[i]) : '0;
        res_prev_q[i] <= sat8(prev_q[i]);
      end
    end
  end

  assign out_o.valid    = res_valid_q;
  assign out_o.status   = res_status_q;
  assign out_o.distance = res_dist_q;
  assign out_o.hit_x    = res_hit_q[0];
  assign out_o.hit_y    = res_hit_q[1];
  assign out_o.hit_z    = res_hit_q[2];
  assign out_o.prev_x   = res_prev_q[0];
  assign out_o.prev_y   = res_prev_q[1];
  assign out_o.prev_z   = res_prev_q[2];

  `include "voxel_grid_ray_march_assert.svh"

  `VGRM_ASSERT_NEXT(a_load_shown, load_out, out_o.valid, "loaded result not presented")
  `VGRM_ASSERT_NOW(a_steps_cap, 1'b1, steps_q <= STEP_W'(MAX_STEPS), "step count beyond limit")
  `VGRM_ASSERT_NOW(a_dist_cap, state_q == S_OUT, t_q <= len_q, "distance beyond ray length")
  `VGRM_ASSERT_NEXT(a_out_hold, out_o.valid && !out_o.ready, out_o.valid && $stable(res_status_q),
                    "result dropped while stalled")

endmodule
